/* rtl/lin_slave_frame_receiver_assert.svh */
// Assertion macros shared by the frame receiver modules.
`ifndef LIN_SLAVE_FRAME_RECEIVER_ASSERT_SVH
`define LIN_SLAVE_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LINRX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("linrx assertion failed");

// Next-cycle implication, off during reset.
`define LINRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("linrx assertion failed");

`endif

/* rtl/linrx_pkg.sv */
// ----------------------------------------------------------------------------
// linrx_pkg
// Types and constants shared by the LIN slave frame receiver.
// ----------------------------------------------------------------------------
package linrx_pkg;

    localparam int FRAME_BYTES_DEF = 8;
    localparam int FRAME_BYTES_MAX = 8;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;

    localparam logic [5:0] RX_ID_RST = 6'h17;
    localparam logic [5:0] TX_ID_RST = 6'h18;
    localparam logic [7:0] SEED_RST  = 8'h97;

    localparam logic [1:0] REG_RX_ID = 2'd0;
    localparam logic [1:0] REG_TX_ID = 2'd1;
    localparam logic [1:0] REG_SEED  = 2'd2;

    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_RX_MATCH  = 3'd1;
    localparam logic [2:0] ST_TX_MATCH  = 3'd2;
    localparam logic [2:0] ST_NO_MATCH  = 3'd3;
    localparam logic [2:0] ST_DATA      = 3'd4;
    localparam logic [2:0] ST_FRAME_OK  = 3'd5;
    localparam logic [2:0] ST_FRAME_BAD = 3'd6;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       after_break;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                     status;
        logic [8*FRAME_BYTES_MAX-1:0]   frame_data;
        logic                           checksum_ok;
    } out_item_t;

    typedef struct packed {
        logic [5:0] rx_id;
        logic [5:0] tx_id;
        logic [7:0] seed;
    } cfg_t;

endpackage

/* rtl/linrx_cfg.sv */
// ----------------------------------------------------------------------------
// linrx_cfg
// APB register file: receive ID, transmit ID and checksum seed.
// ----------------------------------------------------------------------------
module linrx_cfg
    import linrx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [5:0] rx_id_reg;
    logic [5:0] tx_id_reg;
    logic [7:0] seed_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_id_reg <= RX_ID_RST;
            tx_id_reg <= TX_ID_RST;
            seed_reg  <= SEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RX_ID: rx_id_reg <= pwdata[5:0];
                REG_TX_ID: tx_id_reg <= pwdata[5:0];
                REG_SEED:  seed_reg  <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RX_ID: prdata = {{(PDATA_W-6){1'b0}}, rx_id_reg};
            REG_TX_ID: prdata = {{(PDATA_W-6){1'b0}}, tx_id_reg};
            REG_SEED:  prdata = {{(PDATA_W-8){1'b0}}, seed_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.rx_id = rx_id_reg;
    assign cfg.tx_id = tx_id_reg;
    assign cfg.seed  = seed_reg;

endmodule

/* rtl/linrx_core.sv */
// ----------------------------------------------------------------------------
// linrx_core
// Frame state, data store, running sum and checksum check; one byte a cycle on accept.
// ----------------------------------------------------------------------------
`include "lin_slave_frame_receiver_assert.svh"

module linrx_core
    import linrx_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      accept,
    input  in_item_t  item,
    output out_item_t result
);

    localparam int CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

    localparam logic [2:0] PH_AWAIT_ID = 3'd0;
    localparam logic [2:0] PH_RX_DATA  = 3'd1;
    localparam logic [2:0] PH_TX       = 3'd2;
    localparam logic [2:0] PH_RX_CSUM  = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       store_reg [FRAME_BYTES];
    logic             store_we;
    logic [5:0]       id;
    logic [7:0]       csum_exp;
    logic             csum_ok;
    logic [8*FRAME_BYTES_MAX-1:0] frame;

    assign id       = item.bus_byte[5:0];
    assign csum_exp = ~(cfg.seed + sum_reg);
    assign csum_ok  = (item.bus_byte == csum_exp)
                   || ({1'b0, item.bus_byte} + 9'd1 == {1'b0, csum_exp});

    always_comb
    begin
        frame = '0;
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            frame[8*k +: 8] = store_reg[k];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        result     = '0;
        if (item.after_break || phase_reg == PH_AWAIT_ID)
        begin
            cnt_next = '0;
            sum_next = '0;
            priority if (id == cfg.tx_id)
            begin
                phase_next    = PH_TX;
                result.status = ST_TX_MATCH;
            end
            else if (id == cfg.rx_id)
            begin
                phase_next    = PH_RX_DATA;
                result.status = ST_RX_MATCH;
            end
            else
            begin
                phase_next    = PH_AWAIT_ID;
                result.status = ST_NO_MATCH;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_RX_DATA:
                begin
                    store_we      = 1'b1;
                    sum_next      = sum_reg + item.bus_byte;
                    result.status = ST_DATA;
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_RX_CSUM;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_RX_CSUM:
                begin
                    phase_next         = PH_DONE;
                    result.status      = csum_ok ? ST_FRAME_OK : ST_FRAME_BAD;
                    result.frame_data  = frame;
                    result.checksum_ok = csum_ok;
                end
                default:
                begin
                    result.status = ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_AWAIT_ID;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_we)
        begin
            store_reg[cnt_reg] <= item.bus_byte;
        end
    end

    `LINRX_ASSERT_NEXT(a_break_restarts, clk, rst_n, accept && item.after_break, cnt_reg == '0 && sum_reg == '0)
    `LINRX_ASSERT_IMP(a_cnt_only_in_data, clk, rst_n, phase_reg != PH_RX_DATA, cnt_reg == '0)

endmodule

/* rtl/linrx_outq.sv */
// ----------------------------------------------------------------------------
// linrx_outq
// Two-entry result queue between the core and the result channel.
// ----------------------------------------------------------------------------
`include "lin_slave_frame_receiver_assert.svh"

module linrx_outq
    import linrx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      valid,
    input  logic      stall,
    output out_item_t item
);

    out_item_t  q_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign pop   = valid && !stall;
    assign item  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    `LINRX_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, count_reg != 2'd2)
    `LINRX_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1)

endmodule

/* rtl/lin_slave_frame_receiver.sv */
// ----------------------------------------------------------------------------
// lin_slave_frame_receiver
// Receive side of a LIN slave with a seeded checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_stall/byte_item): one bus byte per
//   transaction, with after_break marking the identifier byte.
//   Result channel (result_valid/result_stall/result_item): exactly one
//   result per byte, in order: status, frame_data and checksum_ok.
//   APB port: rx_frame_id at 0x0, tx_frame_id at 0x4, checksum_seed at 0x8.
//   Latency: if no result waits, a result is offered the cycle after its byte.
//   Throughput: one byte per cycle while byte_stall is low; frame state,
//   running sum and check act combinationally between byte channel and queue.
//   The result queue holds two entries; byte_stall rises only when both
//   are filled, so a stalled result channel backs up after two bytes.
//   Reset: frame state returns to awaiting identifier, the result queue
//   empties and the registers take their default values. The data store
//   is not cleared; each frame writes it before it is read.
// ----------------------------------------------------------------------------
module lin_slave_frame_receiver
    import linrx_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  in_item_t           byte_item,
    output logic               result_valid,
    input  logic               result_stall,
    output out_item_t          result_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t      cfg;
    out_item_t core_result;
    logic      accept;
    logic      q_full;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    linrx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    linrx_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (byte_item),
        .result (core_result)
    );

    linrx_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (core_result),
        .full      (q_full),
        .valid     (result_valid),
        .stall     (result_stall),
        .item      (result_item)
    );

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LIN slave frame receiver. A queue-fed driver
// sends bus bytes (directed corner cases, then random frames, breaks and
// noise) under several register settings programmed over APB; a monitor
// compares each result against an in-bench model of the frame decoder.
// ----------------------------------------------------------------------------
module tb
    import linrx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN   = FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 120;

    typedef enum logic [2:0] {
        WAIT_ID,
        RX_DATA,
        TX_SKIP,
        RX_CSUM,
        FRAME_DONE
    } rx_phase_e;

    logic               clk;
    logic               rst_n;
    logic               byte_valid;
    logic               byte_stall;
    in_item_t           byte_item;
    logic               result_valid;
    logic               result_stall;
    out_item_t          result_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lin_slave_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // register copies
    logic [5:0] cfg_rx;
    logic [5:0] cfg_tx;
    logic [7:0] cfg_seed;

    // frame decoder state
    rx_phase_e  rx_phase;
    int         rx_count;
    logic [7:0] rx_sum;
    logic [7:0] rx_store [FRAME_BYTES_MAX];

    in_item_t   pending_bytes[$];
    out_item_t  expected_reports[$];

    int  mismatch_count;
    int  stimulus_count;
    int  accepted_bytes;
    int  frames_good;
    int  frames_bad;
    int  tx_ids;
    int  cycles;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    int  hold_requests;
    int  holds_served;
    bit  sender_idle_en;
    bit  receiver_idle_en;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic log_mismatch(string msg);
        if (mismatch_count < 50)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic out_item_t predict_receiver_report(in_item_t it);
        out_item_t  r;
        logic [8:0] target;
        logic [8:0] got;
        r = '0;
        if (it.after_break || rx_phase == WAIT_ID)
        begin
            rx_count = 0;
            rx_sum   = '0;
            if (it.bus_byte[5:0] == cfg_tx)
            begin
                rx_phase = TX_SKIP;
                r.status = ST_TX_MATCH;
            end
            else if (it.bus_byte[5:0] == cfg_rx)
            begin
                rx_phase = RX_DATA;
                r.status = ST_RX_MATCH;
            end
            else
            begin
                rx_phase = WAIT_ID;
                r.status = ST_NO_MATCH;
            end
        end
        else if (rx_phase == RX_DATA)
        begin
            rx_store[rx_count] = it.bus_byte;
            rx_sum   = rx_sum + it.bus_byte;
            rx_count = rx_count + 1;
            if (rx_count >= FRAME_LEN)
            begin
                rx_count = 0;
                rx_phase = RX_CSUM;
            end
            r.status = ST_DATA;
        end
        else if (rx_phase == RX_CSUM)
        begin
            target = {1'b0, 8'hFF - 8'(cfg_seed + rx_sum)};
            got    = {1'b0, it.bus_byte};
            r.checksum_ok = (got == target) || (got + 9'd1 == target);
            r.status = r.checksum_ok ? ST_FRAME_OK : ST_FRAME_BAD;
            for (int k = 0; k < FRAME_LEN; k++)
                r.frame_data[8*k +: 8] = rx_store[k];
            rx_phase = FRAME_DONE;
        end
        else
        begin
            r.status = ST_IGNORED;
        end
        return r;
    endfunction

    function automatic logic [7:0] checksum_for(logic [7:0] seed, logic [7:0] sum);
        return 8'hFF - 8'(seed + sum);
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                expected_reports.push_back(predict_receiver_report(byte_item));
                accepted_bytes++;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    byte_item  <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    if (sender_idle_en && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 17);
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result, status %0d",
                                           result_item.status));
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (result_item.status !== want.status
                        || result_item.frame_data !== want.frame_data
                        || result_item.checksum_ok !== want.checksum_ok)
                        log_mismatch($sformatf(
                            "status %0d/%0d data %h/%h ok %b/%b (got/exp)",
                            result_item.status, want.status,
                            result_item.frame_data, want.frame_data,
                            result_item.checksum_ok, want.checksum_ok));
                    if (want.status == ST_FRAME_OK)
                        frames_good++;
                    if (want.status == ST_FRAME_BAD)
                        frames_bad++;
                    if (want.status == ST_TX_MATCH)
                        tx_ids++;
                end
            end
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (receiver_idle_en && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b, logic brk);
        in_item_t it;
        it.bus_byte    = b;
        it.after_break = brk;
        pending_bytes.push_back(it);
        stimulus_count++;
    endtask

    task automatic program_register(logic [1:0] idx, logic [7:0] val);
        logic [31:0] mask;
        logic [31:0] got;
        mask = (idx == REG_SEED) ? 32'hFF : 32'h3F;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~mask) | (32'(val) & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RX_ID: cfg_rx   = val[5:0];
            REG_TX_ID: cfg_tx   = val[5:0];
            REG_SEED:  cfg_seed = val;
            default: ;
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (32'(val) & mask))
            log_mismatch($sformatf("register %0d reads %h, wrote %h", idx, got, val));
    endtask

    task automatic apply_settings(logic [5:0] rx, logic [5:0] tx, logic [7:0] seed);
        program_register(REG_RX_ID, {2'b00, rx});
        program_register(REG_TX_ID, {2'b00, tx});
        program_register(REG_SEED, seed);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || byte_valid || expected_reports.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic queue_random_frame();
        int         kind;
        int         n;
        int         pick;
        logic [7:0] sum;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 62)
        begin
            push_byte({2'($urandom()), cfg_rx}, $urandom_range(0, 9) != 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAME_LEN - 1) : FRAME_LEN;
            sum = '0;
            for (int i = 0; i < n; i++)
            begin
                b = 8'($urandom());
                sum = sum + b;
                push_byte(b, 1'b0);
            end
            if (n == FRAME_LEN)
            begin
                pick = $urandom_range(0, 9);
                b = checksum_for(cfg_seed, sum);
                if (pick >= 7)
                    b = 8'($urandom());
                else if (pick >= 4)
                    b = b - 8'd1;
                push_byte(b, 1'b0);
                repeat ($urandom_range(0, 2))
                    push_byte(8'($urandom()), 1'b0);
            end
        end
        else if (kind < 76)
        begin
            push_byte({2'($urandom()), cfg_tx}, 1'b1);
            repeat ($urandom_range(0, 3))
                push_byte(8'($urandom()), 1'b0);
        end
        else
        begin
            repeat ((kind < 90) ? 1 : $urandom_range(1, 3))
            begin
                push_byte(8'($urandom()), 1'($urandom()));
            end
        end
    endtask

    task automatic run_random(int n);
        int target;
        target = stimulus_count + n;
        while (stimulus_count < target)
            queue_random_frame();
    endtask

    task automatic queue_directed();
        logic [7:0] data [8];
        logic [7:0] sum;
        data = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'h55};
        sum = '0;
        // rx id with upper bits set, full frame, checksum one below target
        push_byte(8'hD7, 1'b1);
        foreach (data[i])
        begin
            push_byte(data[i], 1'b0);
            sum = sum + data[i];
        end
        push_byte(checksum_for(cfg_seed, sum) - 8'd1, 1'b0);
        push_byte(8'h17, 1'b0);
        // tx id, then ignored byte
        push_byte(8'h58, 1'b1);
        push_byte(8'h17, 1'b0);
        // unmatched id, then id accepted without break
        push_byte(8'h00, 1'b1);
        push_byte(8'h17, 1'b0);
        // break mid-frame restarts the frame
        push_byte(8'h68, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h97, 1'b1);
        // seed + sum = 0xFF: target is zero, 0xFF must not wrap onto it
        push_byte(8'h68, 1'b0);
        repeat (FRAME_LEN - 1)
            push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_item    = '0;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_rx       = RX_ID_RST;
        cfg_tx       = TX_ID_RST;
        cfg_seed     = SEED_RST;
        rx_phase     = WAIT_ID;
        rx_count     = 0;
        rx_sum       = '0;
        foreach (rx_store[i])
            rx_store[i] = '0;
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();
        run_random(80);
        wait_drained();

        apply_settings(6'd0, 6'd63, 8'd0);
        run_random(100);
        wait_drained();

        // long result hold while bytes keep coming
        apply_settings(6'd63, 6'd0, 8'd255);
        sender_idle_en = 1'b0;
        run_random(100);
        hold_requests++;
        wait_drained();
        sender_idle_en = 1'b1;

        // same id for rx and tx: tx wins
        begin
            logic [5:0] id;
            id = 6'($urandom());
            apply_settings(id, id, 8'($urandom()));
        end
        run_random(80);
        wait_drained();

        apply_settings(6'($urandom()), 6'($urandom()), 8'($urandom()));
        receiver_idle_en = 1'b0;
        run_random(100);
        wait_drained();

        apply_settings(6'($urandom()), 6'($urandom()), 8'($urandom()));
        sender_idle_en = 1'b0;
        run_random(100);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Run covered %0d bus bytes under six register settings, incl. a %0d-cycle hold",
                 accepted_bytes, LONG_HOLD);
        $display("Frames: %0d checksum pass, %0d checksum fail, %0d tx ids; %0d mismatches",
                 frames_good, frames_bad, tx_ids, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/linrx_pkg.sv
rtl/linrx_cfg.sv
rtl/linrx_core.sv
rtl/linrx_outq.sv
rtl/lin_slave_frame_receiver.sv
test/tb.sv
